### sv/wmmr_pkg.sv
// Package: widths, reset constants and state encodings for the min/max/RMS core.
package wmmr_pkg;

   localparam int SAMPLE_W = 14;
   localparam int LEN_W    = 16;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int SUM_W    = 44;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int REM_W    = ROOT_W + 2;
   localparam int SUB_W    = REM_W + 2;
   localparam int STEP_W   = $clog2(SUM_W);

   localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(500);

   typedef logic [SAMPLE_W-1:0] code_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [SUM_W-1:0]    sum_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_ACCUM  = 5'b00100,
      ST_CALC   = 5'b01000,
      ST_LOAD   = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_DIV  = 4'b0010,
      PH_SQRT = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

endpackage

### sv/wmmr_div_sqrt.sv
// Iterative divide then square root over one shared subtractor.
module wmmr_div_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  wmmr_pkg::sum_type      dividend,
   input  wmmr_pkg::len_type      divisor,
   output logic                   done,
   output wmmr_pkg::code_type     root
);
   import wmmr_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   sum_type               work_ff, work_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   len_type               divisor_ff, divisor_in;

   logic [SUB_W-1:0]      sub_a, sub_b;
   logic [SUB_W:0]        sub_diff;
   logic                  sub_borrow;
   logic [LEN_W:0]        div_shift;

   assign div_shift  = {rem_ff[LEN_W-1:0], work_ff[SUM_W-1]};
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[SUB_W];

   always_comb begin
      sub_a = {rem_ff, work_ff[SUM_W-1 -: 2]};
      sub_b = {2'b00, root_ff, 2'b01};
      if (phase_ff == PH_DIV) begin
         sub_a = SUB_W'(div_shift);
         sub_b = SUB_W'(divisor_ff);
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               work_in    = dividend;
               divisor_in = divisor;
               rem_in     = '0;
               step_in    = STEP_W'(SUM_W - 1);
               phase_in   = PH_DIV;
            end
         end
         PH_DIV: begin
            if (sub_borrow) begin
               rem_in  = REM_W'(div_shift);
               work_in = {work_ff[SUM_W-2:0], 1'b0};
            end else begin
               rem_in  = REM_W'(sub_diff[LEN_W:0]);
               work_in = {work_ff[SUM_W-2:0], 1'b1};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W - 1);
               phase_in = PH_SQRT;
            end
         end
         PH_SQRT: begin
            if (sub_borrow) begin
               rem_in  = sub_a[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end else begin
               rem_in  = sub_diff[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      step_ff    <= step_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   assign done = (phase_ff == PH_DONE);
   assign root = root_ff[SAMPLE_W-1:0];

endmodule

### sv/waveform_min_max_rms_core.sv
// Top level: windowed minimum, maximum and RMS of raw ADC codes.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/stall     req_sample
//   rsp      out  rsp_valid/stall     rsp_min_code, rsp_max_code, rsp_rms_code
//   csr      in   csr_wr_en           csr_wr_data (window length)
//
// A sample passes through the states accept, square, accumulate (multiplier then sum adder).
// A window close adds 44 divide and 22 square-root steps on the shared subtractor,
// then a handoff through the done phase and the load state before the next request.
// Reset is synchronous; window length returns to 500 and all accumulators clear.
// The result register frees on rsp acceptance; a full one holds the next result back.
module waveform_min_max_rms_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wmmr_pkg::code_type  req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wmmr_pkg::code_type  rsp_min_code,
   output wmmr_pkg::code_type  rsp_max_code,
   output wmmr_pkg::code_type  rsp_rms_code,
   input  logic                csr_wr_en,
   input  wmmr_pkg::len_type   csr_wr_data
);
   import wmmr_pkg::*;

   state_type           state_ff, state_in;
   len_type             window_len_ff;
   code_type            sample_ff;
   logic [PROD_W-1:0]   prod_ff;
   code_type            min_ff, max_ff;
   sum_type             sum_ff, sum_in;
   len_type             count_ff;
   logic                rsp_valid_ff;
   code_type            rsp_min_ff, rsp_max_ff, rsp_rms_ff;

   logic                calc_start;
   logic                calc_done;
   code_type            calc_root;
   logic [LEN_W:0]      count_next;
   len_type             len_eff;
   logic                window_end;
   logic                out_free;

   assign len_eff    = (window_len_ff == '0) ? LEN_W'(1) : window_len_ff;
   assign count_next = {1'b0, count_ff} + 1'b1;
   assign window_end = (count_next >= {1'b0, len_eff});
   assign sum_in     = sum_ff + SUM_W'(prod_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign calc_start = (state_ff == ST_ACCUM) && window_end;

   wmmr_div_sqrt u_div_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (calc_start),
      .dividend (sum_in),
      .divisor  (count_next[LEN_W-1:0]),
      .done     (calc_done),
      .root     (calc_root)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = window_end ? ST_CALC : ST_IDLE;
         ST_CALC:   if (calc_done) state_in = ST_LOAD;
         ST_LOAD:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WINDOW_RESET;
         min_ff        <= '0;
         max_ff        <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            window_len_ff <= csr_wr_data;
         end
         if (state_ff == ST_ACCUM) begin
            if (count_ff == '0) begin
               min_ff <= sample_ff;
               max_ff <= sample_ff;
            end else begin
               if (sample_ff < min_ff) min_ff <= sample_ff;
               if (sample_ff > max_ff) max_ff <= sample_ff;
            end
            sum_ff <= sum_in;
            if (!window_end) begin
               count_ff <= count_next[LEN_W-1:0];
            end
         end
         if ((state_ff == ST_LOAD) && out_free) begin
            rsp_valid_ff <= 1'b1;
            min_ff       <= '0;
            max_ff       <= '0;
            sum_ff       <= '0;
            count_ff     <= '0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         sample_ff <= req_sample;
      end
      prod_ff <= sample_ff * sample_ff;
      if ((state_ff == ST_LOAD) && out_free) begin
         rsp_min_ff <= min_ff;
         rsp_max_ff <= max_ff;
         rsp_rms_ff <= calc_root;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_code = rsp_min_ff;
   assign rsp_max_code = rsp_max_ff;
   assign rsp_rms_code = rsp_rms_ff;

endmodule
